// ===== sv/gn2o_pkg.sv =====
// shared types and constants for the octave gradient noise block
package gn2o_pkg;

	localparam int COORD_W = 24;
	localparam int SUM_W   = 20;
	localparam int UNIT_W  = 17;

	// configuration register indexes
	localparam logic CFG_OCTAVES = 1'b0;
	localparam logic CFG_PERSIST = 1'b1;

	localparam logic [3:0]  OCT_RESET  = 4'd1;
	localparam logic [15:0] PERS_RESET = 16'd32768;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic [7:0]                 table_index;
		logic [7:0]                 table_value;
		logic signed [COORD_W-1:0]  coord_x;
		logic signed [COORD_W-1:0]  coord_y;
	} item_t;

	typedef struct packed {
		logic [3:0]  octaves;
		logic [15:0] persistence;
	} cfg_t;

endpackage

// ===== sv/gradient_noise_2d_octaves.sv =====
// top level of the octave-summed 2d gradient noise block
// An item is taken when start is high and busy is low; action 0 writes one entry of the
// permutation table, action 1 evaluates noise at the signed Q8.16 point (coord_x, coord_y).
// Each evaluate gives exactly one result, shown on noise_sum and noise_unit for the single
// cycle in which done is high; the receiver cannot stall and writes give no result.
// The front end queues up to two items, so start may be held while the engine works.
// After reset the permutation table is reloaded with identity, one entry a cycle:
// busy stays high until it is done; configuration writes are still taken.
// The engine runs every octave on one shared 34x18 multiplier in 23 steps and takes no new
// item from the queue until an evaluate is finished, so a queued item waits for it;
// that multiplier sets the rate. Write configuration only while the block is idle:
// index 0 octave_count (4 bits, capped at MAX_OCTAVES), index 1 persistence (unsigned Q0.16).
module gradient_noise_2d_octaves
	import gn2o_pkg::*;
#(
	parameter int TABLE_SIZE  = 256,
	parameter int ANGLE_COUNT = 36,
	parameter int MAX_OCTAVES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       action,
	input  logic [7:0]                 table_index,
	input  logic [7:0]                 table_value,
	input  logic signed [COORD_W-1:0]  coord_x,
	input  logic signed [COORD_W-1:0]  coord_y,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [15:0]                cfg_data,
	output logic                       done,
	output logic signed [SUM_W-1:0]    noise_sum,
	output logic [UNIT_W-1:0]          noise_unit
);

	// handshake between front end, queue and engine
	logic  push;
	logic  pop;
	logic  fifo_full;
	logic  fifo_empty;
	logic  clearing;
	item_t push_item;
	item_t pop_item;
	cfg_t  cfg;

	// accepts items, holds configuration
	gn2o_front #(
		.MAX_OCTAVES (MAX_OCTAVES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.table_index (table_index),
		.table_value (table_value),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fifo_full   (fifo_full),
		.clearing    (clearing),
		.busy        (busy),
		.push        (push),
		.push_item   (push_item),
		.cfg         (cfg)
	);

	// short queue decouples acceptance from evaluation
	gn2o_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (fifo_full),
		.empty     (fifo_empty)
	);

	// table owner and octave sequencer
	gn2o_core #(
		.TABLE_SIZE  (TABLE_SIZE),
		.ANGLE_COUNT (ANGLE_COUNT)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.empty      (fifo_empty),
		.item       (pop_item),
		.pop        (pop),
		.clearing   (clearing),
		.done       (done),
		.noise_sum  (noise_sum),
		.noise_unit (noise_unit)
	);

endmodule

// ===== sv/gn2o_front.sv =====
// front end: item acceptance, classification and configuration registers
module gn2o_front
	import gn2o_pkg::*;
#(
	parameter int MAX_OCTAVES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       action,
	input  logic [7:0]                 table_index,
	input  logic [7:0]                 table_value,
	input  logic signed [COORD_W-1:0]  coord_x,
	input  logic signed [COORD_W-1:0]  coord_y,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [15:0]                cfg_data,
	input  logic                       fifo_full,
	input  logic                       clearing,
	output logic                       busy,
	output logic                       push,
	output item_t                      push_item,
	output cfg_t                       cfg
);

	localparam logic [3:0] MAX_OCT = (MAX_OCTAVES > 15) ? 4'd15 : 4'(MAX_OCTAVES);

	logic [3:0]  oct_q;
	logic [15:0] pers_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_q  <= OCT_RESET;
			pers_q <= PERS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OCTAVES: oct_q  <= cfg_data[3:0];
				CFG_PERSIST: pers_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = fifo_full | clearing;
	assign push = start & ~busy;

	always_comb begin
		push_item.op          = action ? OP_EVAL : OP_WRITE;
		push_item.table_index = table_index;
		push_item.table_value = table_value;
		push_item.coord_x     = coord_x;
		push_item.coord_y     = coord_y;
	end

	// octave count saturates at the supported maximum
	assign cfg.octaves     = (oct_q > MAX_OCT) ? MAX_OCT : oct_q;
	assign cfg.persistence = pers_q;

endmodule

// ===== sv/gn2o_fifo.sv =====
// two-entry item queue between front end and noise engine
module gn2o_fifo
	import gn2o_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t pop_item,
	output logic  full,
	output logic  empty
);

	item_t      entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign pop_item = entry_q[rd_q];
	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
`endif

endmodule

// ===== sv/gn2o_core.sv =====
// noise engine: permutation table, gradient rom and shared multiply sequencer
module gn2o_core
	import gn2o_pkg::*;
#(
	parameter int TABLE_SIZE  = 256,
	parameter int ANGLE_COUNT = 36
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      empty,
	input  item_t                     item,
	output logic                      pop,
	output logic                      clearing,
	output logic                      done,
	output logic signed [SUM_W-1:0]   noise_sum,
	output logic [UNIT_W-1:0]         noise_unit
);

	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam longint GAIN = 64'sd652032874;
	localparam longint ATAN [17] = '{
		64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756, 64'sd42667331,
		64'sd21354465, 64'sd10679838, 64'sd5340245, 64'sd2670163, 64'sd1335087,
		64'sd667544, 64'sd333772, 64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861,
		64'sd10430
	};

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RUN, S_FINISH} state_t;

	typedef enum logic [4:0] {
		ST_ROW, ST_COL_A, ST_COL_B, ST_CUBE_X, ST_CUBE_Y, ST_POLY_X, ST_POLY_Y,
		ST_FADE_X, ST_FADE_Y, ST_DOT0, ST_G0, ST_DOT1, ST_G1, ST_DOT2, ST_G2,
		ST_DOT3, ST_G3, ST_LERP0, ST_LERP1, ST_AMP, ST_NOISE, ST_WEIGHT, ST_ACCUM
	} step_t;

	// gradient angle evaluated by integer cordic at elaboration
	function automatic logic signed [17:0] rom_val(input longint ph, input logic want_sin);
		longint p;
		longint z;
		longint xc;
		longint ys;
		longint sx;
		longint sy;
		longint r;
		logic   flip;
		p = ph & 64'hFFFF_FFFF;
		flip = (p >= 64'h4000_0000) && (p < 64'hC000_0000);
		if (flip) begin
			p = (p - 64'h8000_0000) & 64'hFFFF_FFFF;
		end
		z = (p < 64'h8000_0000) ? p : p - 64'h1_0000_0000;
		xc = GAIN;
		ys = 64'sd0;
		for (int i = 0; i < 17; i++) begin
			sx = ys >>> i;
			sy = xc >>> i;
			if (z >= 0) begin
				xc = xc - sx;
				ys = ys + sy;
				z  = z - ATAN[i];
			end else begin
				xc = xc + sx;
				ys = ys - sy;
				z  = z + ATAN[i];
			end
		end
		if (flip) begin
			xc = -xc;
			ys = -ys;
		end
		r = want_sin ? ys : xc;
		return 18'((r + 64'sd8192) >>> 14);
	endfunction

	function automatic logic signed [51:0] rnd16(input logic signed [51:0] v);
		return (v + 52'sd32768) >>> 16;
	endfunction

	function automatic logic [16:0] clamp_u(input logic signed [51:0] r);
		if (r < 52'sd0) begin
			return 17'd0;
		end
		if (r > 52'sd65536) begin
			return 17'd65536;
		end
		return r[16:0];
	endfunction

	// a + b + c reduced modulo the table size, operands already reduced
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b,
	                                           input logic c);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b} + {{AW{1'b0}}, c};
		if (s >= (AW+1)'(TABLE_SIZE)) begin
			s = s - (AW+1)'(TABLE_SIZE);
		end
		return s[AW-1:0];
	endfunction

	logic signed [17:0] cos_tab [256];
	logic signed [17:0] sin_tab [256];
	logic [AW-1:0]      mod_tab [256];

	for (genvar g = 0; g < 256; g++) begin : g_tab
		localparam int HA = g % ANGLE_COUNT;
		localparam longint PH = ((longint'(HA) <<< 32) + longint'(ANGLE_COUNT / 2)) /
			longint'(ANGLE_COUNT);
		localparam logic signed [17:0] CV = rom_val(PH, 1'b0);
		localparam logic signed [17:0] SV = rom_val(PH, 1'b1);
		localparam logic [AW-1:0] MV = AW'(g % TABLE_SIZE);
		assign cos_tab[g] = CV;
		assign sin_tab[g] = SV;
		assign mod_tab[g] = MV;
	end

	state_t state_q;
	step_t  step_q;
	logic [AW-1:0] clr_q;
	logic [3:0]    oct_q;
	logic          done_q;
	logic signed [SUM_W-1:0] noise_sum_q;
	logic [UNIT_W-1:0]       noise_unit_q;

	logic [7:0] perm_mem [TABLE_SIZE];
	logic [7:0] rd0_q;
	logic [7:0] rd1_q;
	logic [AW-1:0] ra0;
	logic [AW-1:0] ra1;
	logic          we;
	logic [AW-1:0] wa;
	logic [7:0]    wd;

	logic [23:0] cx_q;
	logic [23:0] cy_q;
	logic [7:0]  p0_q;
	logic [7:0]  p1_q;
	logic signed [17:0] cos_q [4];
	logic signed [17:0] sin_q [4];
	logic [31:0] tt_q;
	logic [31:0] tty_q;
	logic [16:0] t3x_q;
	logic [16:0] t3y_q;
	logic signed [20:0] inx_q;
	logic signed [20:0] iny_q;
	logic [16:0] ux_q;
	logic [16:0] vy_q;
	logic signed [35:0] dacc_q;
	logic signed [19:0] g_q [4];
	logic signed [19:0] l0_q;
	logic signed [19:0] l1_q;
	logic signed [19:0] noise_q;
	logic [16:0] amp_q;
	logic [16:0] ampn_q;
	logic signed [23:0] sum_q;
	logic signed [51:0] prod_q;

	logic signed [33:0] mul_a;
	logic signed [17:0] mul_b;
	logic [15:0] fx;
	logic [15:0] fy;
	logic [7:0]  ix;
	logic [7:0]  iy;
	logic signed [16:0] dxn;
	logic signed [16:0] dyn;
	logic signed [20:0] kx;
	logic signed [20:0] ky;
	logic signed [SUM_W-1:0]  sat;
	logic [UNIT_W-1:0]        unit;

	assign fx  = cx_q[15:0];
	assign fy  = cy_q[15:0];
	assign ix  = cx_q[23:16];
	assign iy  = cy_q[23:16];
	assign dxn = $signed({1'b1, fx});
	assign dyn = $signed({1'b1, fy});
	assign kx  = $signed({5'd0, fx}) * 21'sd6 - 21'sd983040;
	assign ky  = $signed({5'd0, fy}) * 21'sd6 - 21'sd983040;

	assign pop      = (state_q == S_IDLE) && !empty;
	assign clearing = (state_q == S_CLEAR);

	// table write port: clearing sweep or write item
	always_comb begin
		we = 1'b0;
		wa = clr_q;
		wd = 8'(clr_q);
		if (state_q == S_CLEAR) begin
			we = 1'b1;
		end else if (pop && item.op == OP_WRITE && 32'(item.table_index) < TABLE_SIZE) begin
			we = 1'b1;
			wa = AW'(item.table_index);
			wd = item.table_value;
		end
	end

	// operand and read address selection per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		ra0   = '0;
		ra1   = '0;
		unique case (step_q)
			ST_ROW: begin
				ra0   = mod_tab[ix];
				ra1   = wrap_add(mod_tab[ix], '0, 1'b1);
				mul_a = $signed({18'd0, fx});
				mul_b = $signed({2'd0, fx});
			end
			ST_COL_A: begin
				ra0   = wrap_add(mod_tab[rd0_q], mod_tab[iy], 1'b0);
				ra1   = wrap_add(mod_tab[rd1_q], mod_tab[iy], 1'b0);
				mul_a = $signed({18'd0, fy});
				mul_b = $signed({2'd0, fy});
			end
			ST_COL_B: begin
				ra0   = wrap_add(mod_tab[p0_q], mod_tab[iy], 1'b1);
				ra1   = wrap_add(mod_tab[p1_q], mod_tab[iy], 1'b1);
				mul_a = $signed({2'd0, tt_q});
				mul_b = $signed({2'd0, fx});
			end
			ST_CUBE_X: begin
				mul_a = $signed({2'd0, tty_q});
				mul_b = $signed({2'd0, fy});
			end
			ST_CUBE_Y: begin
				mul_a = 34'(kx);
				mul_b = $signed({2'd0, fx});
			end
			ST_POLY_X: begin
				mul_a = 34'(ky);
				mul_b = $signed({2'd0, fy});
			end
			ST_POLY_Y: begin
				mul_a = 34'(inx_q);
				mul_b = $signed({1'b0, t3x_q});
			end
			ST_FADE_X: begin
				mul_a = 34'(iny_q);
				mul_b = $signed({1'b0, t3y_q});
			end
			ST_FADE_Y: begin
				mul_a = $signed({18'd0, fx});
				mul_b = cos_q[0];
			end
			ST_DOT0: begin
				mul_a = $signed({18'd0, fy});
				mul_b = sin_q[0];
			end
			ST_G0: begin
				mul_a = 34'(dxn);
				mul_b = cos_q[1];
			end
			ST_DOT1: begin
				mul_a = $signed({18'd0, fy});
				mul_b = sin_q[1];
			end
			ST_G1: begin
				mul_a = $signed({18'd0, fx});
				mul_b = cos_q[2];
			end
			ST_DOT2: begin
				mul_a = 34'(dyn);
				mul_b = sin_q[2];
			end
			ST_G2: begin
				mul_a = 34'(dxn);
				mul_b = cos_q[3];
			end
			ST_DOT3: begin
				mul_a = 34'(dyn);
				mul_b = sin_q[3];
			end
			ST_G3: begin
				mul_a = 34'(g_q[1]) - 34'(g_q[0]);
				mul_b = $signed({1'b0, ux_q});
			end
			ST_LERP0: begin
				mul_a = 34'(g_q[3]) - 34'(g_q[2]);
				mul_b = $signed({1'b0, ux_q});
			end
			ST_LERP1: begin
				mul_a = $signed({18'd0, cfg.persistence});
				mul_b = $signed({1'b0, amp_q});
			end
			ST_AMP: begin
				mul_a = 34'(l1_q) - 34'(l0_q);
				mul_b = $signed({1'b0, vy_q});
			end
			ST_WEIGHT: begin
				mul_a = 34'(noise_q);
				mul_b = $signed({1'b0, amp_q});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			perm_mem[wa] <= wd;
		end
		rd0_q <= perm_mem[ra0];
		rd1_q <= perm_mem[ra1];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= 52'(mul_a) * 52'(mul_b);
		if (state_q == S_IDLE) begin
			cx_q  <= item.coord_x;
			cy_q  <= item.coord_y;
			sum_q <= '0;
			amp_q <= 17'd65536;
		end else if (state_q == S_RUN) begin
			case (step_q)
				ST_COL_A: begin
					tt_q <= prod_q[31:0];
					p0_q <= rd0_q;
					p1_q <= rd1_q;
				end
				ST_COL_B: begin
					tty_q    <= prod_q[31:0];
					cos_q[0] <= cos_tab[rd0_q];
					sin_q[0] <= sin_tab[rd0_q];
					cos_q[1] <= cos_tab[rd1_q];
					sin_q[1] <= sin_tab[rd1_q];
				end
				ST_CUBE_X: begin
					t3x_q    <= 17'((prod_q + 52'sd2147483648) >>> 32);
					cos_q[2] <= cos_tab[rd0_q];
					sin_q[2] <= sin_tab[rd0_q];
					cos_q[3] <= cos_tab[rd1_q];
					sin_q[3] <= sin_tab[rd1_q];
				end
				ST_CUBE_Y: t3y_q <= 17'((prod_q + 52'sd2147483648) >>> 32);
				ST_POLY_X: inx_q <= 21'(rnd16(prod_q + 52'sd42949672960));
				ST_POLY_Y: iny_q <= 21'(rnd16(prod_q + 52'sd42949672960));
				ST_FADE_X: ux_q  <= clamp_u(rnd16(prod_q));
				ST_FADE_Y: vy_q  <= clamp_u(rnd16(prod_q));
				ST_DOT0, ST_DOT1, ST_DOT2, ST_DOT3: dacc_q <= 36'(prod_q);
				ST_G0: g_q[0] <= 20'(rnd16(52'(dacc_q) + prod_q));
				ST_G1: g_q[1] <= 20'(rnd16(52'(dacc_q) + prod_q));
				ST_G2: g_q[2] <= 20'(rnd16(52'(dacc_q) + prod_q));
				ST_G3: g_q[3] <= 20'(rnd16(52'(dacc_q) + prod_q));
				ST_LERP0: l0_q <= g_q[0] + 20'(rnd16(prod_q));
				ST_LERP1: l1_q <= g_q[2] + 20'(rnd16(prod_q));
				ST_AMP: ampn_q <= 17'(rnd16(prod_q));
				ST_NOISE: noise_q <= l0_q + 20'(rnd16(prod_q));
				ST_ACCUM: begin
					sum_q <= sum_q + 24'(rnd16(prod_q));
					amp_q <= ampn_q;
					cx_q  <= {cx_q[22:0], 1'b0};
					cy_q  <= {cy_q[22:0], 1'b0};
				end
				default: ;
			endcase
		end
	end

	// saturation and unit remap of the finished sum
	always_comb begin
		if (sum_q > 24'sd524287) begin
			sat = 20'sd524287;
		end else if (sum_q < -24'sd524288) begin
			sat = -20'sd524288;
		end else begin
			sat = 20'(sum_q);
		end
		if (sat <= -20'sd65536) begin
			unit = 17'd0;
		end else if (sat >= 20'sd65536) begin
			unit = 17'd65536;
		end else begin
			unit = 17'((21'(sat) + 21'sd65536) >>> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			step_q       <= ST_ROW;
			clr_q        <= '0;
			oct_q        <= '0;
			done_q       <= 1'b0;
			noise_sum_q  <= '0;
			noise_unit_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!empty && item.op == OP_EVAL) begin
						step_q  <= ST_ROW;
						oct_q   <= '0;
						state_q <= (cfg.octaves == 4'd0) ? S_FINISH : S_RUN;
					end
				end
				S_RUN: begin
					if (step_q == ST_ACCUM) begin
						step_q <= ST_ROW;
						oct_q  <= oct_q + 4'd1;
						if (oct_q + 4'd1 == cfg.octaves) begin
							state_q <= S_FINISH;
						end
					end else begin
						step_q <= step_t'(step_q + 5'd1);
					end
				end
				S_FINISH: begin
					done_q       <= 1'b1;
					noise_sum_q  <= sat;
					noise_unit_q <= unit;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign noise_sum  = noise_sum_q;
	assign noise_unit = noise_unit_q;

`ifndef ASSERT_OFF
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_FINISH))
		else $error("result without finished evaluation");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("result strobe longer than one cycle");
`endif

endmodule
